// ===== rtl/core/pmm_pkg.sv =====
package pmm_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int TOTAL_W         = 32;

    localparam logic [7:0] MASK_CHAR = 8'h58;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_FIRST  = 2'd0,
        REG_PATTERN_SECOND = 2'd1,
        REG_PATTERN_LENGTH = 2'd2,
        REG_MASK_MODE      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [63:0] pattern_first_half;
        logic [63:0] pattern_second_half;
        logic [4:0]  pattern_length;
        logic        mask_mode;
    } pmm_cfg_t;

    typedef struct packed {
        logic [7:0]         data;
        logic               mark;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } pmm_item_t;

    typedef struct packed {
        logic room;
        logic avail;
    } pmm_queue_stat_t;

endpackage

// ===== rtl/core/pmm_front.sv =====
module pmm_front #(
    parameter int MAX_PATTERN = pmm_pkg::MAX_PATTERN_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pmm_pkg::pmm_cfg_t       cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              in_byte,
    input  logic                    end_of_sequence,
    input  logic                    restart_count,
    input  pmm_pkg::pmm_queue_stat_t q_stat,
    output logic                    push,
    output pmm_pkg::pmm_item_t      push_item
);
    import pmm_pkg::*;

    localparam int FW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [MAX_PATTERN-1:0][7:0] win_bytes_reg, win_bytes_next;
    logic [MAX_PATTERN-1:0]      win_marks_reg, win_marks_next;
    logic [FW-1:0]               fill_reg, fill_next;
    logic [FW-1:0]               blocked_reg, blocked_next;
    logic [FW-1:0]               pending_reg, pending_next;
    logic                        pend_eos_reg, pend_eos_next;
    logic [TOTAL_W-1:0]          count_reg, count_next;

    logic [15:0][7:0]            pat_all;
    logic [FW-1:0]               len;
    logic [FW-1:0]               eff;
    logic [MAX_PATTERN-1:0][7:0] wb;
    logic [MAX_PATTERN-1:0]      wm;
    logic [FW-1:0]               fill1;
    logic [FW-1:0]               base;
    logic [FW-1:0]               idx;
    logic                        hit;
    logic [TOTAL_W-1:0]          count_base;
    logic [TOTAL_W-1:0]          count_acc;
    logic [FW-1:0]               n_emit;
    logic                        accept;
    logic                        drain;
    logic [MAX_PATTERN-1:0][7:0] src_bytes;
    logic [MAX_PATTERN-1:0]      src_marks;
    logic [FW-1:0]               src_fill;

    assign pat_all = {cfg.pattern_second_half, cfg.pattern_first_half};

    always_comb
    begin
        if (cfg.pattern_length > 5'(MAX_PATTERN))
            len = FW'(MAX_PATTERN);
        else
            len = cfg.pattern_length[FW-1:0];
        eff = (len == '0) ? FW'(1) : len;
    end

    // append, compare the newest len bytes, count and (in mask mode) mark the occurrence
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            wb[i] = (FW'(i) == fill_reg) ? in_byte : win_bytes_reg[i];
            wm[i] = (FW'(i) == fill_reg) ? 1'b0 : win_marks_reg[i];
        end
        fill1 = fill_reg + FW'(1);
        base  = fill1 - len;
        hit   = (blocked_reg == '0) && (len != '0) && (fill1 >= len);
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            idx = base + FW'(i);
            if (hit && (FW'(i) < len) && (wb[idx[IW-1:0]] != pat_all[i]))
                hit = 1'b0;
        end
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (hit && cfg.mask_mode && (FW'(j) >= base) && (FW'(j) < fill1))
                wm[j] = 1'b1;
        end
        count_base = restart_count ? '0 : count_reg;
        count_acc  = (hit && (count_base != '1)) ? count_base + TOTAL_W'(1) : count_base;
        if (end_of_sequence)
            n_emit = fill1;
        else if (fill1 >= eff)
            n_emit = fill1 - eff + FW'(1);
        else
            n_emit = '0;
    end

    assign in_ready = (pending_reg == '0) && q_stat.room;
    assign accept   = in_valid && in_ready;
    assign drain    = (pending_reg != '0) && q_stat.room;
    assign push     = (accept && (n_emit != '0)) || drain;

    always_comb
    begin
        src_bytes = accept ? wb : win_bytes_reg;
        src_marks = accept ? wm : win_marks_reg;
        src_fill  = accept ? fill1 : fill_reg;

        push_item.data  = src_bytes[0];
        push_item.mark  = src_marks[0];
        push_item.total = accept ? count_acc : count_reg;
        push_item.last  = (accept ? end_of_sequence : pend_eos_reg) && (src_fill == FW'(1));

        win_bytes_next = win_bytes_reg;
        win_marks_next = win_marks_reg;
        fill_next      = fill_reg;
        blocked_next   = blocked_reg;
        pending_next   = pending_reg;
        pend_eos_next  = pend_eos_reg;
        count_next     = count_reg;

        if (accept)
        begin
            count_next    = count_acc;
            pend_eos_next = end_of_sequence;
            if (end_of_sequence)
                blocked_next = '0;
            else if (hit)
                blocked_next = len - FW'(1);
            else if (blocked_reg != '0)
                blocked_next = blocked_reg - FW'(1);
            pending_next   = (n_emit != '0) ? n_emit - FW'(1) : '0;
            win_bytes_next = wb;
            win_marks_next = wm;
            fill_next      = fill1;
        end
        else if (drain)
        begin
            pending_next = pending_reg - FW'(1);
        end

        // oldest entry leaves, the rest move down one place
        if (push)
        begin
            for (int i = 0; i < MAX_PATTERN - 1; i++)
            begin
                win_bytes_next[i] = src_bytes[i + 1];
                win_marks_next[i] = src_marks[i + 1];
            end
            win_bytes_next[MAX_PATTERN-1] = '0;
            win_marks_next[MAX_PATTERN-1] = 1'b0;
            fill_next = src_fill - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_marks_reg <= '0;
            fill_reg      <= '0;
            blocked_reg   <= '0;
            pending_reg   <= '0;
            pend_eos_reg  <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            win_marks_reg <= win_marks_next;
            fill_reg      <= fill_next;
            blocked_reg   <= blocked_next;
            pending_reg   <= pending_next;
            pend_eos_reg  <= pend_eos_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_bytes_reg <= win_bytes_next;
    end

endmodule

// ===== rtl/core/pmm_queue.sv =====
module pmm_queue #(
    parameter int DEPTH = pmm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  pmm_pkg::pmm_item_t       push_item,
    input  logic                     pop,
    output pmm_pkg::pmm_item_t       head_item,
    output pmm_pkg::pmm_queue_stat_t stat
);
    import pmm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pmm_item_t     slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign stat.room  = (count_reg < CW'(DEPTH));
    assign stat.avail = (count_reg != '0);
    assign do_push    = push && stat.room;
    assign do_pop     = pop && stat.avail;
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/core/pmm_back.sv =====
module pmm_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_avail,
    input  pmm_pkg::pmm_item_t                  head_item,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          out_byte,
    output logic                                was_masked,
    output logic [pmm_pkg::TOTAL_W-1:0]         match_total,
    output logic                                last_of_sequence
);
    import pmm_pkg::*;

    logic               valid_reg, valid_next;
    logic [7:0]         byte_reg;
    logic               masked_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               last_reg;

    assign pop = q_avail && (!valid_reg || out_ready);

    always_comb
    begin
        if (pop)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // masked bytes go out as X
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_reg   <= head_item.mark ? MASK_CHAR : head_item.data;
            masked_reg <= head_item.mark;
            total_reg  <= head_item.total;
            last_reg   <= head_item.last;
        end
    end

    assign out_valid        = valid_reg;
    assign out_byte         = byte_reg;
    assign was_masked       = masked_reg;
    assign match_total      = total_reg;
    assign last_of_sequence = last_reg;

endmodule

// ===== rtl/core/pattern_match_masker_top.sv =====
// streaming match of a configured pattern of up to MAX_PATTERN bytes; leftmost
// non-overlapping occurrences are counted (saturating) and, in mask mode, their
// bytes leave as X; output trails input by pattern_length - 1 bytes (none for
// length zero) plus the path through the result queue and output register;
// one byte per cycle in steady state while the result queue has room, set by the
// combinational window compare; a byte with end_of_sequence drains the window at
// that rate and stalls the input until the drain is done; a shorter length written
// mid-sequence drains its excess the same way on the next byte; the user must see
// that configuration is written only while the block is idle (not enforced)
module pattern_match_masker_top #(
    parameter int MAX_PATTERN = pmm_pkg::MAX_PATTERN_DEF,
    parameter int QUEUE_DEPTH = pmm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [pmm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pmm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        in_byte,
    input  logic                              end_of_sequence,
    input  logic                              restart_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        out_byte,
    output logic                              was_masked,
    output logic [pmm_pkg::TOTAL_W-1:0]       match_total,
    output logic                              last_of_sequence
);
    import pmm_pkg::*;

    pmm_cfg_t        cfg_reg, cfg_next;
    pmm_queue_stat_t q_stat;
    pmm_item_t       push_item;
    pmm_item_t       head_item;
    logic            q_push;
    logic            q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_FIRST:  cfg_next.pattern_first_half  = cfg_wdata;
                REG_PATTERN_SECOND: cfg_next.pattern_second_half = cfg_wdata;
                REG_PATTERN_LENGTH: cfg_next.pattern_length      = cfg_wdata[4:0];
                REG_MASK_MODE:      cfg_next.mask_mode           = cfg_wdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    pmm_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_byte         (in_byte),
        .end_of_sequence (end_of_sequence),
        .restart_count   (restart_count),
        .q_stat          (q_stat),
        .push            (q_push),
        .push_item       (push_item)
    );

    pmm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    pmm_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_avail          (q_stat.avail),
        .head_item        (head_item),
        .pop              (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_byte         (out_byte),
        .was_masked       (was_masked),
        .match_total      (match_total),
        .last_of_sequence (last_of_sequence)
    );

    // front never pushes into a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_stat.room)
        else $error("result pushed into full queue");

    // a waiting result reaches an empty output register next cycle
    a_back_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.avail && !out_valid) |=> out_valid)
        else $error("output register did not load");

    // a masked result always carries the mask character
    a_mask_char: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_masked) |-> (out_byte == MASK_CHAR))
        else $error("masked byte is not X");

endmodule

// ===== test/pattern_match_masker_top_tb.sv =====
`timescale 1ns / 100ps

module pattern_match_masker_top_tb;
    import pmm_pkg::*;

    localparam int HALF_PERIOD   = 1;
    localparam int RESET_CYCLES  = 7;
    localparam int WIN_DEPTH     = 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ITEMS   = 40;
    localparam int PHASE_COUNT   = 8;

    typedef struct {
        logic [7:0] value;
        logic       eos;
        logic       restart;
    } seq_byte_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             in_byte = '0;
    logic                   end_of_sequence = 1'b0;
    logic                   restart_count = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [7:0]             out_byte;
    logic                   was_masked;
    logic [TOTAL_W-1:0]     match_total;
    logic                   last_of_sequence;

    // shadow of the configuration registers
    logic [63:0] pat_lo = '0;
    logic [63:0] pat_hi = '0;
    logic [4:0]  pat_len = '0;
    logic        mask_on = 1'b0;

    // predicted delay window
    logic [7:0]         win_byte [WIN_DEPTH];
    logic               win_mark [WIN_DEPTH];
    int                 win_fill = 0;
    int                 skip_left = 0;
    logic [TOTAL_W-1:0] hit_count = '0;

    seq_byte_t seq_feed[$];
    pmm_item_t expected_bytes[$];

    logic in_fire = 1'b0;
    bit   gaps_on = 1'b1;
    bit   stalls_on = 1'b1;
    int   send_gap = 0;
    int   stall_left = 0;
    int   cycle_count = 0;
    int   mismatches = 0;
    int   bytes_sent = 0;
    int   bytes_checked = 0;
    int   occurrences = 0;
    int   configs_run = 0;

    pattern_match_masker_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_byte          (in_byte),
        .end_of_sequence  (end_of_sequence),
        .restart_count    (restart_count),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_byte         (out_byte),
        .was_masked       (was_masked),
        .match_total      (match_total),
        .last_of_sequence (last_of_sequence)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic seq_byte_t pack_byte(logic [7:0] value, logic eos, logic restart);
        seq_byte_t b;
        b.value = value;
        b.eos = eos;
        b.restart = restart;
        return b;
    endfunction

    function automatic logic [7:0] pattern_byte(int i);
        return (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
    endfunction

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 8))
            0, 1: return 8'h41;
            2, 3: return 8'h43;
            4, 5: return 8'h47;
            6, 7: return 8'h54;
            default: return 8'h0A;
        endcase
    endfunction

    function automatic int pick_idle_len();
        int roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    function automatic void shift_out_oldest(logic last);
        pmm_item_t r;
        r.mark = win_mark[0];
        r.data = win_mark[0] ? MASK_CHAR : win_byte[0];
        r.total = hit_count;
        r.last = last;
        expected_bytes.insert(expected_bytes.size(), r);
        for (int i = 0; i < WIN_DEPTH - 1; i++)
        begin
            win_byte[i] = win_byte[i+1];
            win_mark[i] = win_mark[i+1];
        end
        win_byte[WIN_DEPTH-1] = '0;
        win_mark[WIN_DEPTH-1] = 1'b0;
        win_fill--;
    endfunction

    function automatic void predict_masked_bytes(seq_byte_t b);
        int   span;
        int   hold_len;
        int   base;
        logic hit;
        span = (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pat_len);
        hold_len = (span == 0) ? 1 : span;
        if (b.restart)
            hit_count = '0;
        if (win_fill >= WIN_DEPTH)
            win_fill = WIN_DEPTH - 1;
        win_byte[win_fill] = b.value;
        win_mark[win_fill] = 1'b0;
        win_fill++;
        // end positions inside the last occurrence are not searched
        if (skip_left > 0)
            skip_left--;
        else if (span != 0 && win_fill >= span)
        begin
            base = win_fill - span;
            hit = 1'b1;
            for (int i = 0; i < span; i++)
                if (win_byte[base+i] != pattern_byte(i))
                    hit = 1'b0;
            if (hit)
            begin
                if (hit_count != '1)
                    hit_count++;
                if (mask_on)
                    for (int i = 0; i < span; i++)
                        win_mark[base+i] = 1'b1;
                skip_left = span - 1;
                occurrences++;
            end
        end
        if (b.eos)
        begin
            while (win_fill > 0)
                shift_out_oldest(win_fill == 1);
            skip_left = 0;
        end
        else
        begin
            while (win_fill >= hold_len)
                shift_out_oldest(1'b0);
        end
    endfunction

    function automatic void report_mismatch(string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%s", what);
    endfunction

    task automatic load_config(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
                               logic mode);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PATTERN_FIRST;
        cfg_wdata <= lo;
        @(negedge clk);
        cfg_index <= REG_PATTERN_SECOND;
        cfg_wdata <= hi;
        @(negedge clk);
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_wdata <= 64'(len);
        @(negedge clk);
        cfg_index <= REG_MASK_MODE;
        cfg_wdata <= 64'(mode);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        pat_lo = lo;
        pat_hi = hi;
        pat_len = len;
        mask_on = mode;
        configs_run++;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (seq_feed.size() > 0 || in_valid || expected_bytes.size() > 0)
            @(posedge clk);
        // bytes held in the window give no result, so let the pipeline settle
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(int n_items, logic [4:0] len, logic mode, bit wide);
        logic [7:0]  pat [WIN_DEPTH];
        logic [63:0] lo;
        logic [63:0] hi;
        int          span;
        int          added;
        int          seq_len;
        int          roll;
        int          cut;
        int          flip;
        seq_byte_t   run[$];
        span = (len > WIN_DEPTH) ? WIN_DEPTH : int'(len);
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            pat[i] = wide ? 8'($urandom) : pick_letter();
            if (i < 8)
                lo[8*i +: 8] = pat[i];
            else
                hi[8*(i-8) +: 8] = pat[i];
        end
        load_config(lo, hi, len, mode);
        added = 0;
        while (added < n_items)
        begin
            run.delete();
            seq_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 36);
            while (run.size() < seq_len)
            begin
                roll = $urandom_range(0, 99);
                if (span > 0 && roll < 35)
                begin
                    // pattern copy, now and then cut short or with one byte spoiled
                    cut = (roll < 8 && span > 1) ? $urandom_range(1, span - 1) : span;
                    flip = (roll >= 8 && roll < 14) ? $urandom_range(0, span - 1) : -1;
                    for (int i = 0; i < cut; i++)
                        run.insert(run.size(),
                                   pack_byte((i == flip) ? ~pat[i] : pat[i], 1'b0,
                                             $urandom_range(0, 49) == 0));
                end
                else
                begin
                    run.insert(run.size(),
                               pack_byte(wide ? 8'($urandom) : pick_letter(), 1'b0,
                                         $urandom_range(0, 49) == 0));
                end
            end
            added += run.size();
            // the last sequence of a phase may stay open across the next config
            if (added < n_items || $urandom_range(0, 2) != 0)
                run[run.size()-1].eos = 1'b1;
            foreach (run[i])
                seq_feed.insert(seq_feed.size(), run[i]);
        end
    endtask

    // sender: holds each transaction until it is taken
    always @(negedge clk)
    begin : feed_bytes
        seq_byte_t next_up;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (seq_feed.size() > 0)
            begin
                next_up = seq_feed.pop_front();
                in_byte <= next_up.value;
                end_of_sequence <= next_up.eos;
                restart_count <= next_up.restart;
                in_valid <= 1'b1;
                send_gap = gaps_on ? pick_idle_len() : 0;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (stalls_on)
                stall_left = pick_idle_len();
        end
    end

    always @(posedge clk)
    begin : watch_ports
        pmm_item_t want;
        in_fire = rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            bytes_checked++;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf(
                    "unexpected output byte %02h mark %0b total %0d last %0b",
                    out_byte, was_masked, match_total, last_of_sequence));
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.data || was_masked !== want.mark ||
                    match_total !== want.total || last_of_sequence !== want.last)
                    report_mismatch($sformatf(
                        "output %0d: expected byte %02h mark %0b total %0d last %0b, %s",
                        bytes_checked, want.data, want.mark, want.total, want.last,
                        $sformatf("got byte %02h mark %0b total %0d last %0b",
                                  out_byte, was_masked, match_total, last_of_sequence)));
            end
        end
        if (in_fire)
        begin
            bytes_sent++;
            predict_masked_bytes(pack_byte(in_byte, end_of_sequence, restart_count));
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [4:0] len_plan [PHASE_COUNT];
        logic       mode_plan [PHASE_COUNT];
        int         drain;
        len_plan = '{5'd4, 5'd1, 5'd0, 5'd16, 5'd8, 5'd31, 5'd3, 5'd4};
        mode_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        len_plan[7] = 5'($urandom_range(2, 12));
        mode_plan[7] = 1'($urandom_range(0, 1));
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            win_byte[i] = '0;
            win_mark[i] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // overlapping candidates: "AA" against a run of five A
        load_config(64'h4141, '0, 5'd2, 1'b1);
        for (int i = 0; i < 5; i++)
            seq_feed.insert(seq_feed.size(), pack_byte(8'h41, i == 4, i == 0));
        wait_idle();

        // matching off, byte extremes
        load_config('0, '0, 5'd0, 1'b0);
        seq_feed.insert(seq_feed.size(), pack_byte(8'h00, 1'b0, 1'b0));
        seq_feed.insert(seq_feed.size(), pack_byte(8'hFF, 1'b0, 1'b1));
        seq_feed.insert(seq_feed.size(), pack_byte(8'h5A, 1'b1, 1'b0));
        wait_idle();

        // over-long length taken as the full sixteen bytes
        load_config('1, '1, 5'd31, 1'b1);
        for (int i = 0; i < WIN_DEPTH; i++)
            seq_feed.insert(seq_feed.size(),
                            pack_byte(8'hFF, i == WIN_DEPTH - 1, i == 0));
        wait_idle();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            gaps_on = (p != 2);
            stalls_on = (p != 4);
            random_phase(PHASE_ITEMS, len_plan[p], mode_plan[p], p % 3 == 1);
            wait_idle();
        end

        drain = 0;
        while ((seq_feed.size() > 0 || in_valid || expected_bytes.size() > 0) &&
               drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_bytes.size() > 0)
        begin
            mismatches += expected_bytes.size();
            $display("%0d predicted output bytes never appeared", expected_bytes.size());
        end

        $display("sent %0d bytes under %0d configurations, checked %0d output bytes",
                 bytes_sent, configs_run, bytes_checked);
        $display("%0d pattern occurrences predicted, %0d mismatches", occurrences, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pmm_pkg.sv
rtl/core/pmm_front.sv
rtl/core/pmm_queue.sv
rtl/core/pmm_back.sv
rtl/core/pattern_match_masker_top.sv
test/pattern_match_masker_top_tb.sv
